### hdl/confusion_row_categorical_sampler_macros.svh
// assertion helpers used by the sampler rtl
`ifndef CONFUSION_ROW_CATEGORICAL_SAMPLER_MACROS_SVH
`define CONFUSION_ROW_CATEGORICAL_SAMPLER_MACROS_SVH

// same-cycle implication, sampled on clock, off while in reset
`define CRCS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while in reset
`define CRCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/crcs_pkg.sv
`timescale 1ns / 1ps

package crcs_pkg;

   localparam int NUM_COLS   = 8;
   localparam int NUM_STRATA = 4;
   localparam int CLASS_ROWS = 5;

   localparam int PROB_W     = 16;
   localparam int CODE_W     = 8;
   localparam int STRAT_W    = 3;
   localparam int COLF_W     = 3;
   localparam int CSR_W      = 4;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   localparam int ROW_DEPTH  = CLASS_ROWS * NUM_STRATA;
   localparam int ROW_AW     = $clog2(ROW_DEPTH);
   localparam int COL_IDX_W  = $clog2(NUM_COLS);
   localparam int NCOL_W     = $clog2(NUM_COLS + 1);
   localparam int SUM_W      = PROB_W + $clog2(NUM_COLS);
   localparam int HALF       = NUM_COLS / 2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic [CSR_W-1:0] COLS_RESET = CSR_W'(8);

   typedef logic [NUM_COLS-1:0][PROB_W-1:0] row_type;

   // one access to the probability table, issued on an accepted beat
   typedef struct packed {
      logic                 rd_en;
      logic                 wr_en;
      logic [ROW_AW-1:0]    addr;
      logic [COL_IDX_W-1:0] col;
      logic [PROB_W-1:0]    data;
   } tbl_req_type;

   // per-item control carried down the pipe
   typedef struct packed {
      logic              direct;
      logic              missing;
      logic [CODE_W-1:0] cls;
      logic [PROB_W-1:0] frac;
      logic              last;
      logic [NCOL_W-1:0] ncols;
   } item_ctrl_type;

endpackage

### hdl/confusion_row_categorical_sampler.sv
`timescale 1ns / 1ps
// channel   dir  signals                              contents
// req       in   req_tvalid/tready/tdata/tuser/tlast  sample or table load beats
// rsp       out  rsp_tvalid/tready/tdata/tlast        one beat per sample beat
// csr       in   csr_we/csr_wdata                     columns_in_use register
//
// one beat per cycle is accepted while no stall backs up to req; a sample beat reaches rsp through
// registered steps: table row read, half-row prefix sums, compare mask, output register
// load beats write one column ram on the accept edge when code, stratum and column are valid, and give no rsp beat
// reset is synchronous; it clears the valid bits and sets columns_in_use to 8
// each stage holds while the one after it is full and cannot move on, so rsp stalls ripple back
module confusion_row_categorical_sampler (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // code_missing, class_code, stratum, column, probability, random_fraction
   input  logic [crcs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // operation
   input  logic                                 req_tuser,
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_missing, out_class
   output logic [crcs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [crcs_pkg::CSR_W-1:0]           csr_wdata
);
   import crcs_pkg::*;

`include "confusion_row_categorical_sampler_macros.svh"

   logic                     req_accept;
   logic                     req_op;
   logic                     code_missing;
   logic signed [CODE_W-1:0] class_code;
   logic [STRAT_W-1:0]       stratum;
   logic [COLF_W-1:0]        column;
   logic [PROB_W-1:0]        probability;
   logic [PROB_W-1:0]        random_fraction;
   logic                     code_ok;
   logic                     strat_ok;
   logic                     col_ok;
   logic [NCOL_W-1:0]        ncols_eff;

   logic [CSR_W-1:0]         csr_cols_ff;
   tbl_req_type              tbl_req;
   row_type                  row;

   logic                     s1_ready, s2_ready, s3_ready, out_ready;
   logic                     s1_v_ff, s2_v_ff, s3_v_ff, rsp_v_ff;
   logic                     s1_v_in, s2_v_in, s3_v_in, rsp_v_in;
   item_ctrl_type            s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff;
   item_ctrl_type            s1_ctrl_in;
   logic [NUM_COLS-1:0][SUM_W-1:0] s2_pre_ff, s2_pre_in;
   logic [NUM_COLS-1:0]      s3_hit_ff, s3_hit_in;
   logic                     rsp_missing_ff, rsp_missing_in;
   logic [CODE_W-1:0]        rsp_cls_ff, rsp_cls_in;
   logic                     rsp_last_ff;

   assign req_op          = req_tuser;
   assign code_missing    = req_tdata[0];
   assign class_code      = req_tdata[8:1];
   assign stratum         = req_tdata[11:9];
   assign column          = req_tdata[14:12];
   assign probability     = req_tdata[30:15];
   assign random_fraction = req_tdata[46:31];

   assign req_accept = req_tvalid && req_tready;

   assign code_ok  = (class_code >= 1) && (class_code <= CLASS_ROWS);
   assign strat_ok = (stratum != '0) && (32'(stratum) <= NUM_STRATA);
   assign col_ok   = 32'(column) < NUM_COLS;

   // columns register: zero reads as one, too large clamps to the table width
   always_comb begin
      if (csr_cols_ff == '0) begin
         ncols_eff = NCOL_W'(1);
      end else if (32'(csr_cols_ff) > NUM_COLS) begin
         ncols_eff = NCOL_W'(NUM_COLS);
      end else begin
         ncols_eff = NCOL_W'(csr_cols_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cols_ff <= COLS_RESET;
      end else if (csr_we) begin
         csr_cols_ff <= csr_wdata;
      end
   end

   // row address = (stratum - 1) * rows + (code - 1)
   always_comb begin
      tbl_req.rd_en = req_accept;
      tbl_req.wr_en = req_accept && (req_op == OP_LOAD) && code_ok && strat_ok && col_ok;
      tbl_req.addr  = ROW_AW'((32'(stratum) - 32'd1) * CLASS_ROWS
                              + 32'(class_code[2:0]) - 32'd1);
      tbl_req.col   = COL_IDX_W'(column);
      tbl_req.data  = probability;
   end

   crcs_table u_table (
      .clock (clock),
      .req   (tbl_req),
      .row   (row)
   );

   assign out_ready = !rsp_v_ff || rsp_tready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_tready = s1_ready;

   // stage 1: decode the special cases while the row is read
   always_comb begin
      s1_v_in            = req_accept && (req_op == OP_SAMPLE);
      s1_ctrl_in.direct  = 1'b1;
      s1_ctrl_in.missing = 1'b1;
      s1_ctrl_in.cls     = '0;
      s1_ctrl_in.frac    = random_fraction;
      s1_ctrl_in.last    = req_tlast;
      s1_ctrl_in.ncols   = ncols_eff;
      if (code_missing) begin
         s1_ctrl_in.missing = 1'b1;
      end else if (!code_ok) begin
         s1_ctrl_in.missing = 1'b0;
         s1_ctrl_in.cls     = class_code;
      end else if (!strat_ok) begin
         s1_ctrl_in.missing = 1'b1;
      end else begin
         s1_ctrl_in.direct  = 1'b0;
         s1_ctrl_in.missing = 1'b0;
      end
   end

   // stage 2: prefix sums restart at the half-row boundary
   always_comb begin
      s2_v_in = s1_v_ff;
      for (int k = 0; k < NUM_COLS; k++) begin
         if (k == 0 || k == HALF) begin
            s2_pre_in[k] = SUM_W'(row[k]);
         end else begin
            s2_pre_in[k] = s2_pre_in[k-1] + SUM_W'(row[k]);
         end
      end
   end

   // stage 3: join the halves and compare every column at once
   always_comb begin
      logic [SUM_W-1:0] full;
      s3_v_in = s2_v_ff;
      for (int k = 0; k < NUM_COLS; k++) begin
         if (k < HALF) begin
            full = s2_pre_ff[k];
         end else begin
            full = s2_pre_ff[HALF-1] + s2_pre_ff[k];
         end
         s3_hit_in[k] = (SUM_W'(s2_ctrl_ff.frac) <= full)
                        && (NCOL_W'(k) < s2_ctrl_ff.ncols);
      end
   end

   // output: direct results pass through; else first hit wins, no hit saturates to the last column in use
   always_comb begin
      rsp_v_in       = s3_v_ff;
      rsp_missing_in = s3_ctrl_ff.missing;
      rsp_cls_in     = s3_ctrl_ff.cls;
      if (!s3_ctrl_ff.direct) begin
         rsp_cls_in = CODE_W'(s3_ctrl_ff.ncols);
         for (int k = NUM_COLS - 1; k >= 0; k--) begin
            if (s3_hit_ff[k]) begin
               rsp_cls_in = CODE_W'(k + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_v_ff <= s1_v_in;
         end
         if (s2_ready) begin
            s2_v_ff <= s2_v_in;
         end
         if (s3_ready) begin
            s3_v_ff <= s3_v_in;
         end
         if (out_ready) begin
            rsp_v_ff <= rsp_v_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
      if (s2_ready) begin
         s2_ctrl_ff <= s1_ctrl_ff;
         s2_pre_ff  <= s2_pre_in;
      end
      if (s3_ready) begin
         s3_ctrl_ff <= s2_ctrl_ff;
         s3_hit_ff  <= s3_hit_in;
      end
      if (out_ready) begin
         rsp_missing_ff <= rsp_missing_in;
         rsp_cls_ff     <= rsp_cls_in;
         rsp_last_ff    <= s3_ctrl_ff.last;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CODE_W - 1)'(0), rsp_cls_ff, rsp_missing_ff};
   assign rsp_tlast  = rsp_last_ff;

   `CRCS_ASSERT_NEXT(a_load_no_result, req_accept && (req_op == OP_LOAD), !s1_v_ff, "load beat entered the result pipe")
   `CRCS_ASSERT_NEXT(a_missing_direct, req_accept && (req_op == OP_SAMPLE) && code_missing, s1_v_ff && s1_ctrl_ff.direct && s1_ctrl_ff.missing, "missing code not decoded as direct result")
   `CRCS_ASSERT_NEXT(a_s3_hold, s3_v_ff && !out_ready, s3_v_ff, "stalled item dropped from compare stage")
   `CRCS_ASSERT_NOW(a_no_write_on_sample, req_accept && (req_op == OP_SAMPLE), !tbl_req.wr_en, "sample beat wrote the table")

endmodule

### hdl/crcs_ram.sv
`timescale 1ns / 1ps

module crcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 20
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/crcs_table.sv
`timescale 1ns / 1ps

module crcs_table (
   input  logic                 clock,
   input  crcs_pkg::tbl_req_type req,
   output crcs_pkg::row_type     row
);
   import crcs_pkg::*;

   // one narrow ram per column so a whole row is read together
   for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      logic col_we;

      assign col_we = req.wr_en && (req.col == COL_IDX_W'(c));

      crcs_ram #(
         .WIDTH (PROB_W),
         .DEPTH (ROW_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (col_we),
         .wr_addr (req.addr),
         .wr_data (req.data),
         .rd_en   (req.rd_en),
         .rd_addr (req.addr),
         .rd_data (row[c])
      );
   end

endmodule

### test/class_draw_checker.sv
`timescale 1ns / 1ps

module class_draw_checker
   import crcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // code_missing, class_code, stratum, column, probability, random_fraction
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_missing, out_class
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic              missing;
      logic [CODE_W-1:0] cls;
      logic              last;
   } draw_type;

   logic [PROB_W-1:0] weight_tbl [NUM_STRATA][CLASS_ROWS][NUM_COLS];
   logic [CSR_W-1:0]  cols_cfg;
   draw_type          draw_q [$];

   logic               in_missing;
   logic [CODE_W-1:0]  in_code;
   logic [STRAT_W-1:0] in_stratum;
   logic [COLF_W-1:0]  in_column;
   logic [PROB_W-1:0]  in_weight;
   logic [PROB_W-1:0]  in_fraction;

   assign in_missing  = req_tdata[0];
   assign in_code     = req_tdata[8:1];
   assign in_stratum  = req_tdata[11:9];
   assign in_column   = req_tdata[14:12];
   assign in_weight   = req_tdata[30:15];
   assign in_fraction = req_tdata[46:31];

   initial begin
      for (int s = 0; s < NUM_STRATA; s++)
         for (int r = 0; r < CLASS_ROWS; r++)
            for (int c = 0; c < NUM_COLS; c++)
               weight_tbl[s][r][c] = '0;
   end

   // walk the cumulative row sums and pick the first column that covers u
   function automatic draw_type predict_draw(input logic miss, input logic [CODE_W-1:0] code,
                                             input logic [STRAT_W-1:0] strat,
                                             input logic [PROB_W-1:0] u, input logic last);
      draw_type         r;
      int               code_val;
      int               n;
      logic [SUM_W-1:0] run_sum;
      code_val  = $signed(code);
      r.last    = last;
      r.missing = 1'b0;
      r.cls     = code;
      if (miss) begin
         r.missing = 1'b1;
         r.cls     = '0;
      end else if (code_val >= 1 && code_val <= CLASS_ROWS) begin
         if (strat < 1 || strat > NUM_STRATA) begin
            r.missing = 1'b1;
            r.cls     = '0;
         end else begin
            n = (cols_cfg == 0) ? 1 : (cols_cfg > NUM_COLS) ? NUM_COLS : int'(cols_cfg);
            // saturates to the last column when u is above the row total
            r.cls   = CODE_W'(n);
            run_sum = '0;
            for (int k = 0; k < n; k++) begin
               run_sum += weight_tbl[strat-1][code_val-1][k];
               if (u <= run_sum) begin
                  r.cls = CODE_W'(k + 1);
                  break;
               end
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      int       row;
      draw_type want;
      if (reset) begin
         cols_cfg = COLS_RESET;
         draw_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we)
            cols_cfg = csr_wdata;
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            if (draw_q.size() == 0) begin
               $display("%0t: unexpected result beat, got missing=%0b class=%0d last=%0b",
                        $time, rsp_tdata[0], $signed(rsp_tdata[8:1]), rsp_tlast);
               fail_count++;
            end else begin
               want = draw_q.pop_front();
               if (rsp_tdata[0] !== want.missing || rsp_tdata[8:1] !== want.cls ||
                   rsp_tlast !== want.last) begin
                  $display("%0t: mismatch, expected missing=%0b class=%0d last=%0b, %s%0b %s%0d %s%0b",
                           $time, want.missing, $signed(want.cls), want.last,
                           "got missing=", rsp_tdata[0], "class=", $signed(rsp_tdata[8:1]),
                           "last=", rsp_tlast);
                  fail_count++;
               end
            end
         end
         if (req_tvalid === 1'b1 && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               row = $signed(in_code);
               // loads to a bad row, stratum or column are dropped
               if (row >= 1 && row <= CLASS_ROWS && in_stratum >= 1 &&
                   in_stratum <= NUM_STRATA && in_column < NUM_COLS)
                  weight_tbl[in_stratum-1][row-1][in_column] = in_weight;
            end else begin
               draw_q.push_back(predict_draw(in_missing, in_code, in_stratum, in_fraction,
                                             req_tlast));
            end
         end
      end
      outstanding <= draw_q.size();
   end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
   import crcs_pkg::*;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_W-1:0]      csr_wdata  = '0;

   int   fail_count;
   int   outstanding;
   int   idle_pct   = 0;
   int   stall_pct  = 0;
   logic hold_req   = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_left  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   confusion_row_categorical_sampler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   class_draw_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // receiver: random stalls, plus one long hold-off to back the pipe up
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= 80;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #200000;
      $display("confusion_row_categorical_sampler verification failed");
      $finish;
   end

   task automatic drive_beat(input logic op, input logic miss, input logic [CODE_W-1:0] code,
                             input logic [STRAT_W-1:0] strat, input logic [COLF_W-1:0] col,
                             input logic [PROB_W-1:0] prob, input logic [PROB_W-1:0] u,
                             input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, u, prob, col, strat, code, miss};
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1)
         @(posedge clock);
   endtask

   task automatic draw(input logic miss, input logic [CODE_W-1:0] code,
                       input logic [STRAT_W-1:0] strat, input logic [PROB_W-1:0] u,
                       input logic last);
      drive_beat(OP_SAMPLE, miss, code, strat, COLF_W'($urandom), PROB_W'($urandom), u, last);
   endtask

   task automatic store(input logic [CODE_W-1:0] code, input logic [STRAT_W-1:0] strat,
                        input logic [COLF_W-1:0] col, input logic [PROB_W-1:0] prob);
      drive_beat(OP_LOAD, 1'($urandom), code, strat, col, prob, PROB_W'($urandom),
                 1'($urandom));
   endtask

   function automatic logic [PROB_W-1:0] pick_weight();
      case ($urandom_range(19))
         0:       return '0;
         1:       return '1;
         default: return PROB_W'($urandom_range(0, 16383));
      endcase
   endfunction

   function automatic logic [PROB_W-1:0] pick_fraction();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return PROB_W'($urandom);
      endcase
   endfunction

   // wait for the last result, then let any trailing load beats clear the pipe
   task automatic drain();
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         draw(1'b0, CODE_W'($urandom_range(1, CLASS_ROWS)),
              STRAT_W'($urandom_range(1, NUM_STRATA)), pick_fraction(), 1'($urandom));
      end else if (pick < 85) begin
         store(($urandom_range(9) == 0) ? CODE_W'($urandom)
                                        : CODE_W'($urandom_range(1, CLASS_ROWS)),
               ($urandom_range(9) == 0) ? STRAT_W'($urandom)
                                        : STRAT_W'($urandom_range(1, NUM_STRATA)),
               COLF_W'($urandom), pick_weight());
      end else begin
         draw(1'($urandom), CODE_W'($urandom), STRAT_W'($urandom), pick_fraction(),
              1'($urandom));
      end
   endtask

   initial begin : stimulus
      int col_plan [8] = '{8, 1, 0, 15, 3, 8, 5, 2};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // every entry gets written before any sample can read it
      for (int s = 1; s <= NUM_STRATA; s++)
         for (int r = 1; r <= CLASS_ROWS; r++)
            for (int c = 0; c < NUM_COLS; c++)
               store(CODE_W'(r), STRAT_W'(s), COLF_W'(c),
                     (s == 1 && r == 1) ? PROB_W'($urandom_range(0, 2000)) : pick_weight());

      // directed corner cases
      draw(1'b1, 8'd3, 3'd1, 16'd100, 1'b0);
      draw(1'b1, 8'h80, 3'd1, 16'd0, 1'b1);
      draw(1'b0, 8'd0, 3'd2, 16'd500, 1'b0);
      draw(1'b0, 8'd6, 3'd2, 16'd500, 1'b1);
      draw(1'b0, 8'h7F, 3'd3, 16'd0, 1'b0);
      draw(1'b0, 8'hFF, 3'd3, 16'd0, 1'b0);
      draw(1'b0, 8'h80, 3'd4, 16'd0, 1'b1);
      draw(1'b0, 8'd2, 3'd0, 16'd1000, 1'b0);
      draw(1'b0, 8'd2, 3'd5, 16'd1000, 1'b0);
      draw(1'b0, 8'd2, 3'd7, 16'd1000, 1'b1);
      draw(1'b0, 8'd1, 3'd1, 16'd0, 1'b0);
      draw(1'b0, 8'd1, 3'd1, 16'hFFFF, 1'b1);
      store(8'd5, 3'd4, 3'd7, 16'hFFFF);
      store(8'd5, 3'd4, 3'd0, 16'd0);
      draw(1'b0, 8'd5, 3'd4, 16'hFFFF, 1'b0);
      store(8'd0, 3'd1, 3'd0, 16'h1234);
      store(8'd6, 3'd1, 3'd0, 16'h1234);
      store(8'd1, 3'd0, 3'd0, 16'h1234);
      store(8'd1, 3'd5, 3'd0, 16'h1234);
      store(8'h80, 3'd7, 3'd7, 16'hFFFF);
      draw(1'b0, 8'd1, 3'd4, 16'h8000, 1'b1);
      draw(1'b0, 8'd5, 3'd1, 16'h4000, 1'b0);
      req_tvalid <= 1'b0;

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         if (phase > 0) begin
            csr_we    <= 1'b1;
            csr_wdata <= CSR_W'(col_plan[phase]);
            @(posedge clock);
            csr_we    <= 1'b0;
         end
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         if (phase == 4)
            hold_req <= 1'b1;
         repeat (52) random_item();
         req_tvalid <= 1'b0;
      end

      drain();
      if (fail_count == 0 && outstanding == 0)
         $display("confusion_row_categorical_sampler verification clean");
      else
         $display("confusion_row_categorical_sampler verification failed");
      $finish;
   end

endmodule
